@@ rtl/core/spifd_pkg.sv @@
// package: opcodes, phase encoding and shared types of the spi fram slave device
package spifd_pkg;

    localparam int ADDR_BITS_DEF = 13;

    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;

    localparam logic [1:0] BP_NONE    = 2'd0;
    localparam logic [1:0] BP_QUARTER = 2'd1;
    localparam logic [1:0] BP_HALF    = 2'd2;
    localparam logic [1:0] BP_ALL     = 2'd3;

    typedef enum logic [2:0] {
        PH_OPCODE     = 3'd0,
        PH_ADDR_HI    = 3'd1,
        PH_ADDR_LO    = 3'd2,
        PH_READ       = 3'd3,
        PH_WRITE      = 3'd4,
        PH_STATUS_OUT = 3'd5,
        PH_STATUS_IN  = 3'd6,
        PH_IGNORE     = 3'd7
    } phase_t;

    typedef struct packed {
        logic       from_mem;
        logic [7:0] miso_byte;
        logic       blocked;
        logic       latch_now;
    } result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

endpackage

@@ rtl/core/spifd_store.sv @@
// byte storage with a clearing pass after reset and a registered read port
module spifd_store #(
    parameter int ADDR_BITS = spifd_pkg::ADDR_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  spifd_pkg::mem_req_t    req,
    input  logic [ADDR_BITS-1:0]   addr,
    input  logic [7:0]             wr_data,
    output logic [7:0]             rd_data,
    output logic                   ready
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]           mem [0:DEPTH-1];
    logic [7:0]           rd_data_reg;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic [ADDR_BITS-1:0] clr_addr_reg;
    logic [ADDR_BITS-1:0] clr_addr_next;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_BITS'(1);
            if (&clr_addr_reg) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= 8'h00;
        end else if (req.wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

@@ rtl/core/spi_fram_slave_device_unit.sv @@
// top level: spi fram slave device, opcode decode, status register and data streaming
// usage
// s_ channel takes one beat per spi byte exchange or chip-select release;
// s_tuser is the beat kind (0 = byte exchanged, 1 = chip select released),
// s_tdata carries the controller byte and the wp pin level
// m_ channel returns one beat per input beat: the byte driven back, a
// refused flag and the write enable latch after that beat
// from input accept a beat passes the read stage, where the synchronous
// storage read takes place, and then the output register that drives m_tvalid
// throughput is one beat per cycle while m_tready stays high; the control state
// updates at accept, so a new beat enters while the last waits for its storage read
// reset clears the control state and starts a pass that writes zero to every
// storage byte, one per cycle, 2**ADDR_BITS bytes (8192 at the default);
// s_tready stays low until that pass is done
// when the receiver stalls, the output register holds its beat, one more beat
// waits in the read stage and s_tready then drops
module spi_fram_slave_device_unit #(
    parameter int ADDR_BITS = spifd_pkg::ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] mosi_byte, [8] wp_n, [15:9] zero
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] miso_byte, [8] blocked, [9] latch_now, [15:10] zero
);

    spifd_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]           opcode_reg, opcode_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 wel_reg, wel_next;
    logic                 wpen_reg, wpen_next;
    logic [1:0]           bp_reg, bp_next;
    logic                 wss_reg, wss_next;

    logic                 s1_valid_reg;
    spifd_pkg::result_t   s1_res_reg, s1_res_next;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;

    spifd_pkg::mem_req_t  mem_req;
    logic [7:0]           mem_rd_data;
    logic                 store_ready;

    logic                 accept;
    logic                 out_load;
    logic                 cmd;
    logic [7:0]           mosi;
    logic                 wp_n;
    logic                 addr_prot;
    logic [1:0]           addr_top;
    logic [7:0]           status_byte;
    logic [7:0]           out_byte;

    assign cmd  = s_tuser;
    assign mosi = s_tdata[7:0];
    assign wp_n = s_tdata[8];

    assign out_load = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = store_ready && (!s1_valid_reg || out_load);
    assign accept   = s_tvalid && s_tready;

    assign addr_top    = addr_reg[ADDR_BITS-1 -: 2];
    assign status_byte = {wpen_reg, 3'b000, bp_reg, wel_reg, 1'b0};

    always_comb begin
        unique case (bp_reg)
            spifd_pkg::BP_QUARTER: addr_prot = &addr_top;
            spifd_pkg::BP_HALF:    addr_prot = addr_top[1];
            spifd_pkg::BP_ALL:     addr_prot = 1'b1;
            default:               addr_prot = 1'b0;
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (cmd) begin
                phase_next = spifd_pkg::PH_OPCODE;
            end else begin
                unique case (phase_reg)
                    spifd_pkg::PH_OPCODE: begin
                        unique case (mosi)
                            spifd_pkg::OP_RDSR:  phase_next = spifd_pkg::PH_STATUS_OUT;
                            spifd_pkg::OP_WRSR:  phase_next = spifd_pkg::PH_STATUS_IN;
                            spifd_pkg::OP_READ,
                            spifd_pkg::OP_WRITE: phase_next = spifd_pkg::PH_ADDR_HI;
                            default:             phase_next = spifd_pkg::PH_IGNORE;
                        endcase
                    end
                    spifd_pkg::PH_ADDR_HI: phase_next = spifd_pkg::PH_ADDR_LO;
                    spifd_pkg::PH_ADDR_LO: begin
                        phase_next = (opcode_reg == spifd_pkg::OP_READ) ?
                                     spifd_pkg::PH_READ : spifd_pkg::PH_WRITE;
                    end
                    spifd_pkg::PH_STATUS_IN: phase_next = spifd_pkg::PH_IGNORE;
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // datapath and storage requests
    always_comb begin
        opcode_next  = opcode_reg;
        addr_next    = addr_reg;
        wel_next     = wel_reg;
        wpen_next    = wpen_reg;
        bp_next      = bp_reg;
        wss_next     = wss_reg;
        mem_req      = '0;
        s1_res_next  = '0;
        if (accept) begin
            if (cmd) begin
                if (wss_reg) begin
                    wel_next = 1'b0;
                end
                wss_next = 1'b0;
            end else begin
                unique case (phase_reg)
                    spifd_pkg::PH_OPCODE: begin
                        opcode_next = mosi;
                        unique case (mosi)
                            spifd_pkg::OP_WREN:  wel_next = 1'b1;
                            spifd_pkg::OP_WRDI:  wel_next = 1'b0;
                            spifd_pkg::OP_WRSR,
                            spifd_pkg::OP_WRITE: wss_next = 1'b1;
                            default:             wss_next = wss_reg;
                        endcase
                    end
                    spifd_pkg::PH_ADDR_HI: begin
                        addr_next = {mosi[ADDR_BITS-9:0], 8'h00};
                    end
                    spifd_pkg::PH_ADDR_LO: begin
                        addr_next = {addr_reg[ADDR_BITS-1:8], mosi};
                    end
                    spifd_pkg::PH_READ: begin
                        mem_req.rd_en        = 1'b1;
                        s1_res_next.from_mem = 1'b1;
                        addr_next            = addr_reg + ADDR_BITS'(1);
                    end
                    spifd_pkg::PH_WRITE: begin
                        if (wel_reg && !addr_prot) begin
                            mem_req.wr_en = 1'b1;
                        end else begin
                            s1_res_next.blocked = 1'b1;
                        end
                        addr_next = addr_reg + ADDR_BITS'(1);
                    end
                    spifd_pkg::PH_STATUS_OUT: begin
                        s1_res_next.miso_byte = status_byte;
                    end
                    spifd_pkg::PH_STATUS_IN: begin
                        if (!wel_reg || (wpen_reg && !wp_n)) begin
                            s1_res_next.blocked = 1'b1;
                        end else begin
                            wpen_next = mosi[7];
                            bp_next   = mosi[3:2];
                        end
                    end
                    default: begin
                        s1_res_next.miso_byte = 8'h00;
                    end
                endcase
            end
            s1_res_next.latch_now = wel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= spifd_pkg::PH_OPCODE;
            opcode_reg   <= 8'h00;
            addr_reg     <= '0;
            wel_reg      <= 1'b0;
            wpen_reg     <= 1'b0;
            bp_reg       <= spifd_pkg::BP_NONE;
            wss_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            addr_reg   <= addr_next;
            wel_reg    <= wel_next;
            wpen_reg   <= wpen_next;
            bp_reg     <= bp_next;
            wss_reg    <= wss_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (out_load) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign out_byte = s1_res_reg.from_mem ? mem_rd_data : s1_res_reg.miso_byte;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg <= s1_res_next;
        end
        if (out_load) begin
            m_tdata_reg <= {6'b000000, s1_res_reg.latch_now, s1_res_reg.blocked, out_byte};
        end
    end

    spifd_store #(
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .addr    (addr_reg),
        .wr_data (mosi),
        .rd_data (mem_rd_data),
        .ready   (store_ready)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ test/fram_reply_checker.sv @@
// checker for the spi fram slave device: predicts each reply beat and compares it with the dut
module fram_reply_checker
    import spifd_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] mosi_byte, [8] wp_n, [15:9] zero
    input  logic        s_tuser,   // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] miso_byte, [8] blocked, [9] latch_now, [15:10] zero
    output int          fail_count,
    output int          pending_replies
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    typedef struct packed {
        logic [7:0] miso;
        logic       refused;
        logic       wel_after;
    } fram_reply_t;

    phase_t                 link_phase;
    logic [7:0]             held_op;
    logic [ADDR_BITS-1:0]   cur_addr;
    logic                   wel;
    logic                   wpen;
    logic [1:0]             bp;
    logic                   wrote_sel;
    logic [7:0]             mem [0:MEM_WORDS-1];
    fram_reply_t            expected_replies [$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic addr_guarded(input logic [ADDR_BITS-1:0] a);
        case (bp)
            BP_QUARTER: return a >= (MEM_WORDS - MEM_WORDS / 4);
            BP_HALF:    return a >= (MEM_WORDS / 2);
            BP_ALL:     return 1'b1;
            default:    return 1'b0;
        endcase
    endfunction

    task automatic step_fram(input logic release_cs, input logic [7:0] b, input logic wp_n,
                             output fram_reply_t r);
        logic [15:0] wide;
        r = '0;
        wide = 16'h0000;
        if (release_cs) begin
            if (wrote_sel) wel = 1'b0;
            wrote_sel = 1'b0;
            link_phase = PH_OPCODE;
        end else begin
            case (link_phase)
                PH_OPCODE: begin
                    held_op = b;
                    case (b)
                        OP_WREN: begin
                            wel = 1'b1;
                            link_phase = PH_IGNORE;
                        end
                        OP_WRDI: begin
                            wel = 1'b0;
                            link_phase = PH_IGNORE;
                        end
                        OP_RDSR: link_phase = PH_STATUS_OUT;
                        OP_WRSR: begin
                            wrote_sel = 1'b1;
                            link_phase = PH_STATUS_IN;
                        end
                        OP_READ: link_phase = PH_ADDR_HI;
                        OP_WRITE: begin
                            wrote_sel = 1'b1;
                            link_phase = PH_ADDR_HI;
                        end
                        default: link_phase = PH_IGNORE;
                    endcase
                end
                PH_ADDR_HI: begin
                    wide = {b, 8'h00};
                    cur_addr = wide[ADDR_BITS-1:0];
                    link_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    wide = {8'h00, b};
                    cur_addr = cur_addr | wide[ADDR_BITS-1:0];
                    link_phase = (held_op == OP_READ) ? PH_READ : PH_WRITE;
                end
                PH_READ: begin
                    r.miso = mem[cur_addr];
                    cur_addr = cur_addr + 1'b1;
                end
                PH_WRITE: begin
                    if (wel && !addr_guarded(cur_addr)) mem[cur_addr] = b;
                    else r.refused = 1'b1;
                    cur_addr = cur_addr + 1'b1;
                end
                PH_STATUS_OUT: r.miso = {wpen, 3'b000, bp, wel, 1'b0};
                PH_STATUS_IN: begin
                    if (!wel || (wpen && !wp_n)) begin
                        r.refused = 1'b1;
                    end else begin
                        wpen = b[7];
                        bp = b[3:2];
                    end
                    link_phase = PH_IGNORE;
                end
                default: ;
            endcase
        end
        r.wel_after = wel;
    endtask

    always @(posedge aclk) begin
        fram_reply_t want;
        fram_reply_t got;
        if (!aresetn) begin
            link_phase = PH_OPCODE;
            held_op = 8'h00;
            cur_addr = '0;
            wel = 1'b0;
            wpen = 1'b0;
            bp = BP_NONE;
            wrote_sel = 1'b0;
            for (int i = 0; i < MEM_WORDS; i++) mem[i] = 8'h00;
            expected_replies.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                step_fram(s_tuser, s_tdata[7:0], s_tdata[8], want);
                expected_replies.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[8], m_tdata[9]};
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("reply beat 0x%h with none expected", m_tdata));
                end else begin
                    want = expected_replies.pop_front();
                    if (got.miso !== want.miso)
                        report_mismatch($sformatf("miso_byte 0x%h, want 0x%h",
                                                  got.miso, want.miso));
                    if (got.refused !== want.refused)
                        report_mismatch($sformatf("blocked %b, want %b",
                                                  got.refused, want.refused));
                    if (got.wel_after !== want.wel_after)
                        report_mismatch($sformatf("latch_now %b, want %b",
                                                  got.wel_after, want.wel_after));
                end
            end
        end
        pending_replies = expected_replies.size();
    end

endmodule

@@ test/spi_fram_slave_device_unit_tb.sv @@
// testbench top: drives spi byte and deselect beats into the fram slave and gives the verdict
module spi_fram_slave_device_unit_tb;
    import spifd_pkg::*;

    localparam logic       CMD_EXCHANGE = 1'b0;
    localparam logic       CMD_RELEASE  = 1'b1;
    localparam logic [7:0] OP_UNUSED    = 8'h70;
    localparam int         TOTAL_BEATS  = 1650;
    localparam int         QUIET_LIMIT  = 40000;
    localparam int         DRAIN_CYCLES = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;   // [7:0] mosi_byte, [8] wp_n, [15:9] zero
    logic        s_tuser = 1'b0;       // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;              // [7:0] miso_byte, [8] blocked, [9] latch_now, [15:10] zero

    int fail_count;
    int pending_replies;
    int beats_sent = 0;
    int send_idle_pct = 18;
    int recv_idle_pct = 48;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    spi_fram_slave_device_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fram_reply_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_replies (pending_replies)
    );

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic pin_level();
        return $urandom_range(3) != 0;
    endfunction

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'h1FF0 + 16'($urandom_range(31));
            2:       return 16'h17F8 + 16'($urandom_range(15));
            default: return 16'h0FF8 + 16'($urandom_range(15));
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [7:0] b, input logic wp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, wp, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic byte_beat(input logic [7:0] b);
        send_beat(CMD_EXCHANGE, b, pin_level());
    endtask

    task automatic release_cs();
        send_beat(CMD_RELEASE, 8'($urandom), pin_level());
    endtask

    task automatic short_cmd(input logic [7:0] op, input int extra);
        byte_beat(op);
        repeat (extra) byte_beat(8'($urandom));
        release_cs();
    endtask

    task automatic mem_burst(input logic [7:0] op, input logic [15:0] a, input int n);
        byte_beat(op);
        byte_beat(a[15:8]);
        byte_beat(a[7:0]);
        repeat (n) byte_beat(8'($urandom));
        release_cs();
    endtask

    task automatic status_write(input logic [7:0] val, input logic wp);
        byte_beat(OP_WRSR);
        send_beat(CMD_EXCHANGE, val, wp);
        release_cs();
    endtask

    task automatic random_transaction();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            short_cmd(OP_WREN, $urandom_range(2));
        end else if (pick < 17) begin
            short_cmd(OP_WRDI, $urandom_range(2));
        end else if (pick < 45) begin
            if ($urandom_range(4) != 0) short_cmd(OP_WREN, 0);
            mem_burst(OP_WRITE, pick_addr(), $urandom_range(6));
        end else if (pick < 70) begin
            mem_burst(OP_READ, pick_addr(), $urandom_range(6));
        end else if (pick < 77) begin
            short_cmd(OP_RDSR, $urandom_range(3));
        end else if (pick < 84) begin
            if ($urandom_range(4) != 0) short_cmd(OP_WREN, 0);
            status_write(8'($urandom), pin_level());
        end else if (pick < 92) begin
            short_cmd(8'($urandom), $urandom_range(3));
        end else begin
            byte_beat(($urandom_range(1) != 0) ? OP_READ : OP_WRITE);
            repeat ($urandom_range(1)) byte_beat(8'($urandom));
            release_cs();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: cleared memory, refusals, address wrap, protection and pin lock
        release_cs();
        short_cmd(OP_RDSR, 1);
        mem_burst(OP_READ, 16'h0000, 1);
        mem_burst(OP_WRITE, 16'h0010, 1);
        short_cmd(OP_WREN, 0);
        mem_burst(OP_WRITE, 16'hFFFF, 2);
        mem_burst(OP_READ, 16'hFFFF, 2);
        status_write(8'h04, 1'b1);
        short_cmd(OP_WREN, 1);
        status_write(8'h8C, 1'b1);
        short_cmd(OP_WREN, 0);
        mem_burst(OP_WRITE, 16'h0000, 1);
        short_cmd(OP_WREN, 0);
        status_write(8'h00, 1'b0);
        short_cmd(OP_WREN, 0);
        status_write(8'h00, 1'b1);
        short_cmd(OP_UNUSED, 2);
        short_cmd(OP_WRDI, 1);

        while (beats_sent < TOTAL_BEATS) begin
            if (beats_sent < TOTAL_BEATS / 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 48;
            end else if (beats_sent < 2 * TOTAL_BEATS / 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_transaction();
        end
        s_tvalid <= 1'b0;

        while (pending_replies != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_replies == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
